// File: design/lobm_pkg.sv
// ---------------------------------------------------------------------------
// lobm_pkg
// Shared constants, types and helpers for the limit order book matcher.
// ---------------------------------------------------------------------------
package lobm_pkg;

  localparam int BOOK_DEPTH = 256;
  localparam int VALUE_BITS = 16;
  localparam int OUT_W      = 16;
  localparam int IDX_W      = $clog2(BOOK_DEPTH);
  localparam int CNT_W      = IDX_W + 1;

  // book select codes
  localparam logic BK_ASK = 1'b0;
  localparam logic BK_BID = 1'b1;

  // one resting order
  typedef struct packed {
    logic [VALUE_BITS-1:0] price;
    logic [VALUE_BITS-1:0] qty;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // strictly better price for the given book
  function automatic logic better(input logic is_bid, input logic [VALUE_BITS-1:0] x,
                                  input logic [VALUE_BITS-1:0] y);
    better = is_bid ? (x > y) : (x < y);
  endfunction

endpackage

// File: design/lobm_if.sv
// ---------------------------------------------------------------------------
// lobm_if
// Order and result channels, valid/ready handshake.
// ---------------------------------------------------------------------------
interface lobm_in_if;
  logic        valid;
  logic        ready;
  logic        side;
  logic [15:0] quantity;
  logic [15:0] limit_price;

  modport source (output valid, side, quantity, limit_price, input ready);
  modport sink   (input valid, side, quantity, limit_price, output ready);
endinterface

interface lobm_out_if;
  logic        valid;
  logic        ready;
  logic        ask_valid;
  logic [15:0] ask_price;
  logic        bid_valid;
  logic [15:0] bid_price;
  logic        trade_valid;
  logic [15:0] trade_price;
  logic        dropped;

  modport source (output valid, ask_valid, ask_price, bid_valid, bid_price,
                  trade_valid, trade_price, dropped, input ready);
  modport sink   (input valid, ask_valid, ask_price, bid_valid, bid_price,
                  trade_valid, trade_price, dropped, output ready);
endinterface

// File: design/lobm_ram.sv
// ---------------------------------------------------------------------------
// lobm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lobm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/limit_order_book_matcher_unit.sv
// ---------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Bid and ask heaps in RAM, one sift sequencer shared by both books.
//
//   channel  dir  handshake     word
//   in_ch    in   valid/ready   side, quantity, limit_price
//   out_ch   out  valid/ready   ask/bid tops, last trade, dropped
//
// one order at a time: accepted only when idle, result held until taken
// insert climbs one heap level per ST_INS_UP/ST_INS_CMP pair (the parent is read
// through the one registered RAM read port); each match is followed by one pop,
// two on equal quantities; a pop goes straight to ST_POP_END when the book empties,
// else loads the last entry and descends via ST_DN_L, ST_DN_R, ST_DN_CMP per level
// reset empties both books at once, no clearing pass
// ---------------------------------------------------------------------------
module limit_order_book_matcher_unit (
  input logic       clk,
  input logic       rst_n,
  lobm_in_if.sink   in_ch,
  lobm_out_if.source out_ch
);
  import lobm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INS_UP, ST_INS_CMP, ST_MATCH, ST_POP, ST_POP_LD,
    ST_DN_L, ST_DN_R, ST_DN_CMP, ST_POP_END, ST_RESP
  } state_t;

  state_t           state_r, state_nxt;
  logic             bk_r, bk_nxt;
  logic             sec_r, sec_nxt;
  logic             use_r_r, use_r_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] ci_r, ci_nxt;
  entry_t           e_r, e_nxt;
  entry_t           c_r, c_nxt;
  logic [CNT_W-1:0] bid_cnt_r, bid_cnt_nxt, ask_cnt_r, ask_cnt_nxt;
  entry_t           bid_top_r, ask_top_r;
  logic             trade_v_r, trade_v_nxt;
  logic [VALUE_BITS-1:0] trade_p_r, trade_p_nxt;
  logic             drop_r, drop_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             o_ask_v_r, o_bid_v_r, o_trade_v_r, o_drop_r;
  logic [OUT_W-1:0] o_ask_p_r, o_bid_p_r, o_trade_p_r;
  logic             latch_out;

  // ram control
  logic             we, wbk;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata;
  entry_t           bid_rdata, ask_rdata, rdata;

  logic [CNT_W-1:0] cur_cnt, n_w, l_w;
  logic [CNT_W:0]   r_w;
  logic [IDX_W-1:0] par_w;
  entry_t           child_w;
  logic [IDX_W-1:0] child_i_w;
  logic             in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign cur_cnt = bk_r ? bid_cnt_r : ask_cnt_r;
  assign rdata   = bk_r ? bid_rdata : ask_rdata;
  assign n_w     = cur_cnt - CNT_W'(1);
  assign l_w     = {i_r, 1'b1};
  assign r_w     = {1'b0, l_w} + (CNT_W+1)'(1);
  assign par_w   = (i_r - IDX_W'(1)) >> 1;

  // better of the two children
  always_comb begin
    child_w   = c_r;
    child_i_w = ci_r;
    if (use_r_r && better(bk_r, rdata.price, c_r.price)) begin
      child_w   = rdata;
      child_i_w = ci_r + IDX_W'(1);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    bk_nxt        = bk_r;
    sec_nxt       = sec_r;
    use_r_nxt     = use_r_r;
    i_nxt         = i_r;
    ci_nxt        = ci_r;
    e_nxt         = e_r;
    c_nxt         = c_r;
    bid_cnt_nxt   = bid_cnt_r;
    ask_cnt_nxt   = ask_cnt_r;
    trade_v_nxt   = trade_v_r;
    trade_p_nxt   = trade_p_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    latch_out     = 1'b0;
    we            = 1'b0;
    wbk           = bk_r;
    waddr         = i_r;
    wdata         = e_r;
    raddr         = par_w;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          drop_nxt = 1'b0;
          bk_nxt   = in_ch.side;
          e_nxt    = '{price: VALUE_BITS'(in_ch.limit_price),
                       qty:   VALUE_BITS'(in_ch.quantity)};
          if (in_ch.quantity == '0) begin
            state_nxt = ST_MATCH;
          end else if (in_ch.side == BK_BID) begin
            if (bid_cnt_r == CNT_W'(BOOK_DEPTH)) begin
              drop_nxt  = 1'b1;
              state_nxt = ST_MATCH;
            end else begin
              i_nxt       = bid_cnt_r[IDX_W-1:0];
              bid_cnt_nxt = bid_cnt_r + CNT_W'(1);
              state_nxt   = ST_INS_UP;
            end
          end else begin
            if (ask_cnt_r == CNT_W'(BOOK_DEPTH)) begin
              drop_nxt  = 1'b1;
              state_nxt = ST_MATCH;
            end else begin
              i_nxt       = ask_cnt_r[IDX_W-1:0];
              ask_cnt_nxt = ask_cnt_r + CNT_W'(1);
              state_nxt   = ST_INS_UP;
            end
          end
        end
      end
      // sift up: fetch parent or settle at the root
      ST_INS_UP: begin
        if (i_r == '0) begin
          we        = 1'b1;
          state_nxt = ST_MATCH;
        end else begin
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        we = 1'b1;
        if (better(bk_r, e_r.price, rdata.price)) begin
          wdata     = rdata;
          i_nxt     = par_w;
          state_nxt = ST_INS_UP;
        end else begin
          state_nxt = ST_MATCH;
        end
      end
      // cross the tops while they overlap
      ST_MATCH: begin
        if (bid_cnt_r != '0 && ask_cnt_r != '0 && bid_top_r.price >= ask_top_r.price) begin
          trade_v_nxt = 1'b1;
          trade_p_nxt = ask_top_r.price;
          sec_nxt     = 1'b0;
          waddr       = '0;
          state_nxt   = ST_POP;
          if (bid_top_r.qty < ask_top_r.qty) begin
            we     = 1'b1;
            wbk    = BK_ASK;
            wdata  = '{price: ask_top_r.price, qty: ask_top_r.qty - bid_top_r.qty};
            bk_nxt = BK_BID;
          end else if (bid_top_r.qty == ask_top_r.qty) begin
            bk_nxt  = BK_BID;
            sec_nxt = 1'b1;
          end else begin
            we     = 1'b1;
            wbk    = BK_BID;
            wdata  = '{price: bid_top_r.price, qty: bid_top_r.qty - ask_top_r.qty};
            bk_nxt = BK_ASK;
          end
        end else begin
          latch_out     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_RESP;
        end
      end
      // remove the top, fetch the last entry
      ST_POP: begin
        if (bk_r == BK_BID) begin
          bid_cnt_nxt = n_w;
        end else begin
          ask_cnt_nxt = n_w;
        end
        raddr = n_w[IDX_W-1:0];
        state_nxt = (n_w == '0) ? ST_POP_END : ST_POP_LD;
      end
      ST_POP_LD: begin
        e_nxt     = rdata;
        i_nxt     = '0;
        state_nxt = ST_DN_L;
      end
      // sift down: left child
      ST_DN_L: begin
        raddr = l_w[IDX_W-1:0];
        if (l_w >= cur_cnt) begin
          we        = 1'b1;
          state_nxt = ST_POP_END;
        end else begin
          state_nxt = ST_DN_R;
        end
      end
      // right child if present
      ST_DN_R: begin
        c_nxt     = rdata;
        ci_nxt    = l_w[IDX_W-1:0];
        raddr     = r_w[IDX_W-1:0];
        use_r_nxt = (r_w < {1'b0, cur_cnt});
        state_nxt = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        we = 1'b1;
        if (better(bk_r, child_w.price, e_r.price)) begin
          wdata     = child_w;
          i_nxt     = child_i_w;
          state_nxt = ST_DN_L;
        end else begin
          state_nxt = ST_POP_END;
        end
      end
      ST_POP_END: begin
        if (sec_r) begin
          sec_nxt   = 1'b0;
          bk_nxt    = BK_ASK;
          state_nxt = ST_POP;
        end else begin
          state_nxt = ST_MATCH;
        end
      end
      ST_RESP: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bid_cnt_r   <= '0;
      ask_cnt_r   <= '0;
      trade_v_r   <= 1'b0;
      trade_p_r   <= '0;
      out_valid_r <= 1'b0;
      sec_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bid_cnt_r   <= bid_cnt_nxt;
      ask_cnt_r   <= ask_cnt_nxt;
      trade_v_r   <= trade_v_nxt;
      trade_p_r   <= trade_p_nxt;
      out_valid_r <= out_valid_nxt;
      sec_r       <= sec_nxt;
    end
  end

  // payload and cached tops
  always_ff @(posedge clk) begin
    bk_r    <= bk_nxt;
    use_r_r <= use_r_nxt;
    i_r     <= i_nxt;
    ci_r    <= ci_nxt;
    e_r     <= e_nxt;
    c_r     <= c_nxt;
    drop_r  <= drop_nxt;
    if (we && waddr == '0 && wbk == BK_BID) begin
      bid_top_r <= wdata;
    end
    if (we && waddr == '0 && wbk == BK_ASK) begin
      ask_top_r <= wdata;
    end
    if (latch_out) begin
      o_ask_v_r   <= (ask_cnt_r != '0);
      o_ask_p_r   <= (ask_cnt_r != '0) ? ask_top_r.price[OUT_W-1:0] : '0;
      o_bid_v_r   <= (bid_cnt_r != '0);
      o_bid_p_r   <= (bid_cnt_r != '0) ? bid_top_r.price[OUT_W-1:0] : '0;
      o_trade_v_r <= trade_v_r;
      o_trade_p_r <= trade_p_r[OUT_W-1:0];
      o_drop_r    <= drop_r;
    end
  end

  // heap storage
  lobm_ram #(.WIDTH(ENTRY_W), .DEPTH(BOOK_DEPTH)) u_bid_ram (
    .clk   (clk),
    .we    (we && wbk == BK_BID),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (bid_rdata)
  );

  lobm_ram #(.WIDTH(ENTRY_W), .DEPTH(BOOK_DEPTH)) u_ask_ram (
    .clk   (clk),
    .we    (we && wbk == BK_ASK),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ask_rdata)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.ask_valid   = o_ask_v_r;
  assign out_ch.ask_price   = o_ask_p_r;
  assign out_ch.bid_valid   = o_bid_v_r;
  assign out_ch.bid_price   = o_bid_p_r;
  assign out_ch.trade_valid = o_trade_v_r;
  assign out_ch.trade_price = o_trade_p_r;
  assign out_ch.dropped     = o_drop_r;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("order taken while a result is pending");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bid_cnt_r <= CNT_W'(BOOK_DEPTH) && ask_cnt_r <= CNT_W'(BOOK_DEPTH))
    else $error("book count beyond depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("ready after accepting an order");

  a_uncrossed_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> !(out_ch.ask_valid && out_ch.bid_valid &&
                              out_ch.bid_price >= out_ch.ask_price))
    else $error("result shows a crossed book");

endmodule
